// ----- src/grid_line_of_sight_check_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the grid line-of-sight block
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GRID_LINE_OF_SIGHT_CHECK_MACROS_SVH
`define GRID_LINE_OF_SIGHT_CHECK_MACROS_SVH

// property must hold at every edge out of reset
`define GLOS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// expression must never be true out of reset
`define GLOS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

// ----- src/glos_pkg.sv -----
// ---------------------------------------------------------------------------
// glos_pkg
// Shared widths, codes and controller/datapath structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package glos_pkg;

    localparam int COORD_W    = 6;               // x / y field width
    localparam int COORD_SPAN = 2 ** COORD_W;    // addressable coordinates
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int ERR_W      = COORD_W + 3;     // signed Bresenham error term

    localparam logic [CFG_DATA_W-1:0] CFG_COUNT_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic clear;     // clearing sweep writes one cell
        logic do_write;  // write item: store cell, result 0
        logic start;     // query item: load line
        logic step;      // walk one point
    } t_cmd;

    typedef struct packed {
        logic clear_done; // sweep at last cell
        logic at_end;     // walk point equals end point
    } t_sts;

endpackage

// ----- src/glos_if.sv -----
// ---------------------------------------------------------------------------
// glos channel interfaces
// Input item, result item and configuration write channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface glos_item_if import glos_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               op;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic               cell_blocked;

    modport source (output valid, op, x0, y0, x1, y1, cell_blocked, input ready);
    modport sink   (input valid, op, x0, y0, x1, y1, cell_blocked, output ready);
endinterface

interface glos_result_if ();
    logic valid;
    logic ready;
    logic path_clear;

    modport source (output valid, path_clear, input ready);
    modport sink   (input valid, path_clear, output ready);
endinterface

interface glos_cfg_if import glos_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/grid_line_of_sight_check.sv -----
// ---------------------------------------------------------------------------
// grid_line_of_sight_check
// One-bit occupancy grid with cell writes and Bresenham line-of-sight queries.
// ---------------------------------------------------------------------------
//
//   channel   dir  payload                              notes
//   i_item    in   op, x0, y0, x1, y1, cell_blocked     one item per query/write
//   o_result  out  path_clear                           one result per item
//   i_cfg     in   index, data                          row_count / column_count
//
// A write item goes to the done state, which loads the result register once
// that register is free; the next item is then taken in idle. A query walks
// the line, one line point per cycle, bounded by the single grid memory read
// port, then passes the drain and done states before the result is loaded.
// After reset a clearing sweep writes one cell a cycle over all 2**AW grid
// memory cells (4096 at 64 x 64); no item is accepted then, config writes are.
// The result register lets a new item in while the previous result is stalled;
// a finished result waits in the controller until that register frees up.
//
`timescale 1ns / 1ps

module grid_line_of_sight_check import glos_pkg::*; #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    glos_item_if.sink     i_item,
    glos_result_if.source o_result,
    glos_cfg_if.sink      i_cfg
);

    // configuration registers: bounds for the query walk only
    logic [CFG_DATA_W-1:0] r_row_count;
    logic [CFG_DATA_W-1:0] r_column_count;

    // result register, decouples the walk from a stalled sink
    logic r_out_valid;
    logic r_path_clear;

    t_cmd cmd;
    t_sts sts;
    logic load_out;
    logic out_free;
    logic dp_path_clear;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= CFG_COUNT_RESET;
            r_column_count <= CFG_COUNT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ROW_COUNT:    r_row_count    <= i_cfg.data;
                REG_COLUMN_COUNT: r_column_count <= i_cfg.data;
                default: begin
                    // unmapped index: ignored
                end
            endcase
        end
    end

    assign out_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_path_clear <= dp_path_clear;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.path_clear = r_path_clear;

    glos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_op       (i_item.op),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_in_ready (i_item.ready),
        .o_cmd      (cmd),
        .o_load_out (load_out)
    );

    glos_dp #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_x0           (i_item.x0),
        .i_y0           (i_item.y0),
        .i_x1           (i_item.x1),
        .i_y1           (i_item.y1),
        .i_cell_blocked (i_item.cell_blocked),
        .i_row_count    (r_row_count),
        .i_column_count (r_column_count),
        .o_sts          (sts),
        .o_path_clear   (dp_path_clear)
    );

endmodule

// ----- src/glos_ctrl.sv -----
// ---------------------------------------------------------------------------
// glos_ctrl
// Sequencer: clearing sweep, item intake, line walk, result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_line_of_sight_check_macros.svh"

module glos_ctrl import glos_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_op,
    input  logic i_out_free,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd,
    output logic o_load_out
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_load_out = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_op == OP_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_WALK;
                    end else begin
                        o_cmd.do_write = 1'b1;
                        n_state        = S_DONE;
                    end
                end
            end
            S_WALK: begin
                if (i_sts.at_end) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DRAIN: begin
                // spare state before the hand-off; the last grid check has already updated r_clear
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `GLOS_ASSERT(a_query_walks, i_in_valid && o_in_ready && (i_op == OP_QUERY) |=> r_state == S_WALK, "query did not enter walk")
    `GLOS_ASSERT(a_load_needs_slot, o_load_out |-> i_out_free, "result loaded into full slot")
    `GLOS_ASSERT(a_cmd_onehot, $onehot0({o_cmd.clear, o_cmd.do_write, o_cmd.start, o_cmd.step}), "conflicting datapath commands")

endmodule

// ----- src/glos_dp.sv -----
// ---------------------------------------------------------------------------
// glos_dp
// Occupancy memory, Bresenham stepper and blocked-cell accumulator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_line_of_sight_check_macros.svh"

module glos_dp import glos_pkg::*; #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [COORD_W-1:0]    i_x0,
    input  logic [COORD_W-1:0]    i_y0,
    input  logic [COORD_W-1:0]    i_x1,
    input  logic [COORD_W-1:0]    i_y1,
    input  logic                  i_cell_blocked,
    input  logic [CFG_DATA_W-1:0] i_row_count,
    input  logic [CFG_DATA_W-1:0] i_column_count,
    output t_sts                  o_sts,
    output logic                  o_path_clear
);

    // only cells reachable by 6-bit coordinates are stored
    localparam int EFF_W = (GRID_W < COORD_SPAN) ? GRID_W : COORD_SPAN;
    localparam int EFF_H = (GRID_H < COORD_SPAN) ? GRID_H : COORD_SPAN;
    localparam int XW    = $clog2(EFF_W);
    localparam int YW    = $clog2(EFF_H);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 2 ** AW;
    localparam logic [CFG_DATA_W-1:0] EFF_W_V = CFG_DATA_W'(EFF_W);
    localparam logic [CFG_DATA_W-1:0] EFF_H_V = CFG_DATA_W'(EFF_H);

    logic r_grid [DEPTH];

    logic [AW-1:0]             r_clr_addr;
    logic [COORD_W-1:0]        r_x, r_y, r_xe, r_ye, r_dx, r_dy;
    logic                      r_sx, r_sy;
    logic signed [ERR_W-1:0]   r_err;
    logic                      r_rd_data;
    logic                      r_chk;
    logic                      r_clear;

    logic [COORD_W-1:0]        dx_in, dy_in;
    logic signed [ERR_W:0]     e2, dx_e, dy_e;
    logic signed [ERR_W-1:0]   dx_n, dy_n, n_err;
    logic                      step_x, step_y;
    logic [CFG_DATA_W-1:0]     lim_x, lim_y;
    logic                      in_range, wr_in_grid, we, wdata;
    logic [AW-1:0]             waddr, raddr;

    assign dx_in = (i_x1 > i_x0) ? (i_x1 - i_x0) : (i_x0 - i_x1);
    assign dy_in = (i_y1 > i_y0) ? (i_y1 - i_y0) : (i_y0 - i_y1);

    // e2 = 2*err against -dy and dx
    assign e2     = {r_err, 1'b0};
    assign dx_e   = $signed((ERR_W + 1)'(r_dx));
    assign dy_e   = $signed((ERR_W + 1)'(r_dy));
    assign dx_n   = $signed(ERR_W'(r_dx));
    assign dy_n   = $signed(ERR_W'(r_dy));
    assign step_x = e2 > -dy_e;
    assign step_y = e2 < dx_e;
    assign n_err  = r_err - (step_x ? dy_n : ERR_W'(0)) + (step_y ? dx_n : ERR_W'(0));

    assign lim_x    = (i_column_count < EFF_W_V) ? i_column_count : EFF_W_V;
    assign lim_y    = (i_row_count < EFF_H_V) ? i_row_count : EFF_H_V;
    assign in_range = (CFG_DATA_W'(r_x) < lim_x) && (CFG_DATA_W'(r_y) < lim_y);

    assign wr_in_grid = (CFG_DATA_W'(i_x0) < EFF_W_V) && (CFG_DATA_W'(i_y0) < EFF_H_V);
    assign we    = i_cmd.clear || (i_cmd.do_write && wr_in_grid);
    assign waddr = i_cmd.clear ? r_clr_addr : {i_y0[YW-1:0], i_x0[XW-1:0]};
    assign wdata = i_cmd.clear ? 1'b0 : i_cell_blocked;
    assign raddr = {r_y[YW-1:0], r_x[XW-1:0]};

    assign o_sts.clear_done = (r_clr_addr == {AW{1'b1}});
    assign o_sts.at_end     = (r_x == r_xe) && (r_y == r_ye);
    assign o_path_clear     = r_clear;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_grid[waddr] <= wdata;
        end
        r_rd_data <= r_grid[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_chk      <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            // read issued this cycle is checked next cycle
            r_chk <= i_cmd.step && in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x   <= i_x0;
            r_y   <= i_y0;
            r_xe  <= i_x1;
            r_ye  <= i_y1;
            r_dx  <= dx_in;
            r_dy  <= dy_in;
            r_sx  <= i_x0 < i_x1;
            r_sy  <= i_y0 < i_y1;
            r_err <= $signed(ERR_W'(dx_in)) - $signed(ERR_W'(dy_in));
        end else if (i_cmd.step) begin
            r_err <= n_err;
            if (step_x) begin
                r_x <= r_sx ? (r_x + COORD_W'(1)) : (r_x - COORD_W'(1));
            end
            if (step_y) begin
                r_y <= r_sy ? (r_y + COORD_W'(1)) : (r_y - COORD_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.do_write) begin
            r_clear <= 1'b0;
        end else if (i_cmd.start) begin
            r_clear <= 1'b1;
        end else if (r_chk && r_rd_data) begin
            r_clear <= 1'b0;
        end
    end

    `GLOS_ASSERT(a_chk_after_step, r_chk |-> $past(i_cmd.step), "grid check without walk step")
    `GLOS_ASSERT(a_write_result_zero, $past(i_cmd.do_write) |-> !o_path_clear, "write item result not zero")

endmodule

// ----- sim/tb_grid_line_of_sight_check.sv -----
// ---------------------------------------------------------------------------
// tb_grid_line_of_sight_check
// Self-checking bench: a directed table of grid writes, line-of-sight queries
// and count-register writes, then random phases over several count settings.
// Results are matched to hand answers or a model of the occupancy grid and the
// Bresenham walk. Both channels idle at random, with one long result stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_grid_line_of_sight_check import glos_pkg::*; ();

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 11;
    localparam int GRID_W       = 64;
    localparam int GRID_H       = 64;

    // Index 3 maps to no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Random part: about 1850 items spread over eight count settings.
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 232;
    localparam int PRESSURE_PHASE  = 4;
    localparam int PRESSURE_ITEMS  = 64;
    localparam int HOLD_OFF_CYCLES = 600;

    // Longest query walks 63 points; the tail covers that twice over.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 150;

    // Cycles with no handshake on any channel. The worst honest stretch is
    // the clearing sweep after reset or the long result hold-off; a single
    // slow item (query + sender gap + result stall) takes less.
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic               cell_blocked;
    } t_grid_item;

    // ROW_KNOWN rows carry a hand-derived answer, ROW_PREDICTED rows use
    // the model, ROW_CFG rows write a count register.
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_KNOWN,
        ROW_PREDICTED
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_grid_item            item;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        logic                  known_clear;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 25;

    logic i_clk;
    logic i_rst_n;

    glos_item_if   item_if ();
    glos_result_if result_if ();
    glos_cfg_if    cfg_if ();

    grid_line_of_sight_check #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    // ---------------------------------------------------------------------
    // Model state: the grid, the two counts, and path_clear values in
    // accept order waiting for their result items.
    // ---------------------------------------------------------------------
    logic                  occ_grid [0:GRID_H-1][0:GRID_W-1];
    logic [CFG_DATA_W-1:0] rows_in_use;
    logic [CFG_DATA_W-1:0] cols_in_use;
    logic                  expected_clear [$];

    int   mismatch_count = 0;
    int   quiet_cycles = 0;
    logic sender_gapless;
    logic hold_off_pending;

    //            kind           op        x0     y0     x1     y1   blk
    //                           reg index         value  known answer
    t_directed_row directed_tbl [DIRECTED_ROWS] = '{
        // empty grid, full diagonal and a zero-length line
        '{ROW_KNOWN, '{OP_QUERY, 6'd0, 6'd0, 6'd63, 6'd63, 1'b0},
            REG_ROW_COUNT, 7'd0, 1'b1},
        '{ROW_KNOWN, '{OP_QUERY, 6'd5, 6'd5, 6'd5, 6'd5, 1'b1},
            REG_ROW_COUNT, 7'd0, 1'b1},
        // block two corners; writes always answer 0, end fields ignored
        '{ROW_KNOWN, '{OP_WRITE, 6'd63, 6'd63, 6'd33, 6'd12, 1'b1},
            REG_ROW_COUNT, 7'd0, 1'b0},
        '{ROW_KNOWN, '{OP_WRITE, 6'd0, 6'd0, 6'd63, 6'd63, 1'b1},
            REG_ROW_COUNT, 7'd0, 1'b0},
        // the start point is visited, so a blocked start blocks the line
        '{ROW_KNOWN, '{OP_QUERY, 6'd0, 6'd0, 6'd63, 6'd63, 1'b0},
            REG_ROW_COUNT, 7'd0, 1'b0},
        '{ROW_KNOWN, '{OP_QUERY, 6'd63, 6'd63, 6'd0, 6'd0, 1'b1},
            REG_ROW_COUNT, 7'd0, 1'b0},
        // the end point is never looked at
        '{ROW_PREDICTED, '{OP_QUERY, 6'd1, 6'd1, 6'd63, 6'd63, 1'b0},
            REG_ROW_COUNT, 7'd0, 1'b0},
        '{ROW_KNOWN, '{OP_WRITE, 6'd63, 6'd0, 6'd0, 6'd0, 1'b1},
            REG_ROW_COUNT, 7'd0, 1'b0},
        '{ROW_PREDICTED, '{OP_QUERY, 6'd0, 6'd63, 6'd63, 6'd0, 1'b0},
            REG_ROW_COUNT, 7'd0, 1'b0},
        '{ROW_KNOWN, '{OP_QUERY, 6'd63, 6'd0, 6'd0, 6'd63, 1'b0},
            REG_ROW_COUNT, 7'd0, 1'b0},
        // one obstacle hit by horizontal, vertical and steep lines
        '{ROW_KNOWN, '{OP_WRITE, 6'd10, 6'd20, 6'd0, 6'd0, 1'b1},
            REG_ROW_COUNT, 7'd0, 1'b0},
        '{ROW_PREDICTED, '{OP_QUERY, 6'd0, 6'd20, 6'd63, 6'd20, 1'b0},
            REG_ROW_COUNT, 7'd0, 1'b0},
        '{ROW_PREDICTED, '{OP_QUERY, 6'd10, 6'd63, 6'd10, 6'd0, 1'b0},
            REG_ROW_COUNT, 7'd0, 1'b0},
        '{ROW_PREDICTED, '{OP_QUERY, 6'd9, 6'd0, 6'd11, 6'd40, 1'b0},
            REG_ROW_COUNT, 7'd0, 1'b0},
        // free a cell again
        '{ROW_KNOWN, '{OP_WRITE, 6'd0, 6'd0, 6'd0, 6'd0, 1'b0},
            REG_ROW_COUNT, 7'd0, 1'b0},
        '{ROW_PREDICTED, '{OP_QUERY, 6'd0, 6'd0, 6'd0, 6'd5, 1'b0},
            REG_ROW_COUNT, 7'd0, 1'b0},
        // zero rows in use: every point skipped
        '{ROW_CFG, '{OP_WRITE, 6'd0, 6'd0, 6'd0, 6'd0, 1'b0},
            REG_ROW_COUNT, 7'd0, 1'b0},
        '{ROW_KNOWN, '{OP_QUERY, 6'd63, 6'd63, 6'd0, 6'd0, 1'b0},
            REG_ROW_COUNT, 7'd0, 1'b1},
        // counts above the grid act as the grid size
        '{ROW_CFG, '{OP_WRITE, 6'd0, 6'd0, 6'd0, 6'd0, 1'b0},
            REG_ROW_COUNT, 7'd127, 1'b0},
        '{ROW_CFG, '{OP_WRITE, 6'd0, 6'd0, 6'd0, 6'd0, 1'b0},
            REG_COLUMN_COUNT, 7'd127, 1'b0},
        '{ROW_KNOWN, '{OP_QUERY, 6'd63, 6'd63, 6'd0, 6'd0, 1'b0},
            REG_ROW_COUNT, 7'd0, 1'b0},
        // column 10 falls outside a count of 10
        '{ROW_CFG, '{OP_WRITE, 6'd0, 6'd0, 6'd0, 6'd0, 1'b0},
            REG_COLUMN_COUNT, 7'd10, 1'b0},
        '{ROW_KNOWN, '{OP_QUERY, 6'd10, 6'd0, 6'd10, 6'd63, 1'b0},
            REG_ROW_COUNT, 7'd0, 1'b1},
        // unmapped index, then the column-10 line again under the model
        '{ROW_CFG, '{OP_WRITE, 6'd0, 6'd0, 6'd0, 6'd0, 1'b0},
            REG_SPARE, 7'd0, 1'b0},
        '{ROW_PREDICTED, '{OP_QUERY, 6'd10, 6'd0, 6'd10, 6'd63, 1'b0},
            REG_ROW_COUNT, 7'd0, 1'b0}
    };

    // ---------------------------------------------------------------------
    // Model: a write stores the cell and answers 0; a query walks the line
    // from the start point, stopping short of the end point, and fails on
    // the first blocked cell inside the counts in use.
    // ---------------------------------------------------------------------
    function automatic logic predict_path_clear(t_grid_item it);
        int x, y, xe, ye, dx, dy, sx, sy, err, e2, lim_x, lim_y;
        if (it.op == OP_WRITE) begin
            occ_grid[it.y0][it.x0] = it.cell_blocked;
            return 1'b0;
        end
        x     = it.x0;
        y     = it.y0;
        xe    = it.x1;
        ye    = it.y1;
        dx    = (xe > x) ? xe - x : x - xe;
        dy    = (ye > y) ? ye - y : y - ye;
        sx    = (x < xe) ? 1 : -1;
        sy    = (y < ye) ? 1 : -1;
        err   = dx - dy;
        lim_y = (rows_in_use < GRID_H) ? int'(rows_in_use) : GRID_H;
        lim_x = (cols_in_use < GRID_W) ? int'(cols_in_use) : GRID_W;
        while (!(x == xe && y == ye)) begin
            e2 = 2 * err;
            // the walk stays inside the endpoints' box, so x, y >= 0 here
            if (y < lim_y && x < lim_x && occ_grid[y][x]) begin
                return 1'b0;
            end
            if (e2 > -dy) begin
                err -= dy;
                x   += sx;
            end
            if (e2 < dx) begin
                err += dx;
                y   += sy;
            end
        end
        return 1'b1;
    endfunction

    // Mostly no gap, some short ones, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 50);
    endfunction

    // Most coordinates fall in the phase window so lines meet obstacles.
    function automatic logic [COORD_W-1:0] pick_coord(int origin, int span);
        if ($urandom_range(0, 9) < 7) begin
            return COORD_W'(origin + $urandom_range(0, span - 1));
        end
        return COORD_W'($urandom_range(0, COORD_SPAN - 1));
    endfunction

    // Offers one item and returns at the edge it is taken. valid is left
    // high there; the next call either reuses it or lowers it first.
    task automatic send_item(input t_grid_item it, input logic known,
                             input logic known_clear);
        int   gap;
        logic model_clear;
        gap = sender_gapless ? 0 : pick_gap();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid        <= 1'b1;
        item_if.op           <= it.op;
        item_if.x0           <= it.x0;
        item_if.y0           <= it.y0;
        item_if.x1           <= it.x1;
        item_if.y1           <= it.y1;
        item_if.cell_blocked <= it.cell_blocked;
        do @(posedge i_clk); while (!item_if.ready);
        model_clear = predict_path_clear(it);
        expected_clear.push_back(known ? known_clear : model_clear);
    endtask

    task automatic wait_for_results();
        while (expected_clear.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Count registers change only with the block idle.
    task automatic write_count(input logic [CFG_IDX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] value);
        item_if.valid <= 1'b0;
        wait_for_results();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (index)
            REG_ROW_COUNT:    rows_in_use = value;
            REG_COLUMN_COUNT: cols_in_use = value;
            default: ;
        endcase
    endtask

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Result side: alternating runs of ready and stalls, plus one long
    // hold-off on request so the block backs up into its input.
    // ---------------------------------------------------------------------
    initial begin : result_sink
        logic hold_off_done;
        hold_off_done = 1'b0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_pending && !hold_off_done) begin
                hold_off_done = 1'b1;
                result_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                result_if.ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end else begin
                result_if.ready <= 1'b1;
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(100, 300)) @(posedge i_clk);
                end else begin
                    repeat ($urandom_range(1, 40)) @(posedge i_clk);
                end
            end
        end
    end

    // Each result is matched against the oldest waiting expectation.
    always @(posedge i_clk) begin : result_check
        logic want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_clear.size() == 0) begin
                $error("path_clear: result with no item waiting, actual %0b",
                       result_if.path_clear);
                mismatch_count++;
            end else begin
                want = expected_clear.pop_front();
                if (result_if.path_clear !== want) begin
                    $error("path_clear mismatch: expected %0b actual %0b",
                           want, result_if.path_clear);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends a hung run: no handshake on any channel for too long.
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) ||
            (result_if.valid && result_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus: reset, directed table, then random phases.
    // ---------------------------------------------------------------------
    initial begin : stimulus
        t_grid_item            it;
        int                    phase;
        int                    n;
        int                    span;
        int                    org_x;
        int                    org_y;
        logic [CFG_DATA_W-1:0] rows_set;
        logic [CFG_DATA_W-1:0] cols_set;

        sender_gapless   = 1'b0;
        hold_off_pending = 1'b0;
        rows_in_use      = CFG_COUNT_RESET;
        cols_in_use      = CFG_COUNT_RESET;
        foreach (occ_grid[r, c]) occ_grid[r][c] = 1'b0;

        i_rst_n              <= 1'b0;
        item_if.valid        <= 1'b0;
        item_if.op           <= OP_WRITE;
        item_if.x0           <= '0;
        item_if.y0           <= '0;
        item_if.x1           <= '0;
        item_if.y1           <= '0;
        item_if.cell_blocked <= 1'b0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= REG_ROW_COUNT;
        cfg_if.data          <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part; the first item waits out the clearing sweep.
        foreach (directed_tbl[i]) begin
            case (directed_tbl[i].kind)
                ROW_CFG:   write_count(directed_tbl[i].reg_index,
                                       directed_tbl[i].reg_value);
                ROW_KNOWN: send_item(directed_tbl[i].item, 1'b1,
                                     directed_tbl[i].known_clear);
                default:   send_item(directed_tbl[i].item, 1'b0, 1'b0);
            endcase
        end
        write_count(REG_COLUMN_COUNT, 7'd0);
        it = '{OP_QUERY, 6'd63, 6'd63, 6'd0, 6'd0, 1'b0};
        send_item(it, 1'b1, 1'b1);

        // Random phases: fixed extremes first, then random counts, each
        // phase working a window of its own to keep obstacles dense.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin rows_set = 7'd64;  cols_set = 7'd64;  end
                1: begin rows_set = 7'd127; cols_set = 7'd127; end
                2: begin rows_set = 7'd1;   cols_set = 7'd64;  end
                3: begin rows_set = 7'd64;  cols_set = 7'd1;   end
                default: begin
                    rows_set = ($urandom_range(0, 7) == 0) ?
                               7'($urandom_range(65, 127)) : 7'($urandom_range(2, 64));
                    cols_set = ($urandom_range(0, 7) == 0) ?
                               7'($urandom_range(65, 127)) : 7'($urandom_range(2, 64));
                end
            endcase
            write_count(REG_ROW_COUNT, rows_set);
            write_count(REG_COLUMN_COUNT, cols_set);

            case ($urandom_range(0, 3))
                0:       span = 4;
                1:       span = 8;
                2:       span = 16;
                default: span = 64;
            endcase
            org_x = $urandom_range(0, COORD_SPAN - span);
            org_y = $urandom_range(0, COORD_SPAN - span);

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) begin
                    sender_gapless = ($urandom_range(0, 3) == 0);
                end
                // back-pressure: result side stalls, input keeps coming
                if (phase == PRESSURE_PHASE && n == 0) begin
                    hold_off_pending = 1'b1;
                end
                if (phase == PRESSURE_PHASE && n < PRESSURE_ITEMS) begin
                    sender_gapless = 1'b1;
                end
                it.op           = ($urandom_range(0, 99) < 55) ? OP_QUERY : OP_WRITE;
                it.x0           = pick_coord(org_x, span);
                it.y0           = pick_coord(org_y, span);
                it.x1           = pick_coord(org_x, span);
                it.y1           = pick_coord(org_y, span);
                it.cell_blocked = ($urandom_range(0, 3) != 0);
                if (it.op == OP_QUERY && $urandom_range(0, 19) == 0) begin
                    it.x1 = it.x0;
                    it.y1 = it.y0;
                end
                send_item(it, 1'b0, 1'b0);
            end
        end

        item_if.valid <= 1'b0;
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
